// ===== hw/rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types for the point-to-segment squared distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int NUM_COORDS     = 6;
	localparam int OUT_BITS       = 33;
	localparam int OUT_TDATA_W    = 40;
	localparam int REGION_W       = 2;
	localparam int FRONT_STAGES   = 4;

	typedef enum logic [REGION_W-1:0] {
		REGION_START    = 2'd0,
		REGION_END      = 2'd1,
		REGION_INTERIOR = 2'd2
	} region_t;

endpackage

// ===== hw/rtl/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Four-stage front end: differences, products, dot and cross sums, then the
// squared cross product, the region decision and the endpoint distance.
// ----------------------------------------------------------------------------
module psd_front #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8
) (
	input  logic                            clk,
	input  logic [3:0]                      stage_en,
	input  logic signed [COORD_BITS-1:0]    start_x,
	input  logic signed [COORD_BITS-1:0]    start_y,
	input  logic signed [COORD_BITS-1:0]    end_x,
	input  logic signed [COORD_BITS-1:0]    end_y,
	input  logic signed [COORD_BITS-1:0]    point_x,
	input  logic signed [COORD_BITS-1:0]    point_y,
	output logic [2*COORD_BITS:0]           len_sq,
	output logic [4*COORD_BITS+1:0]         cross_sq,
	output logic [2*COORD_BITS+FRAC_BITS:0] ep_dist,
	output psd_pkg::region_t                region
);
	import psd_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int RW = 2 * COORD_BITS + 1;
	localparam int QW = RW + FRAC_BITS;

	// Stage 1: coordinate differences.
	logic signed [DW-1:0] ux_s1, uy_s1, rx_s1, ry_s1, wx_s1, wy_s1;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ux_s1 <= DW'(end_x) - DW'(start_x);
			uy_s1 <= DW'(end_y) - DW'(start_y);
			rx_s1 <= DW'(point_x) - DW'(start_x);
			ry_s1 <= DW'(point_y) - DW'(start_y);
			wx_s1 <= DW'(point_x) - DW'(end_x);
			wy_s1 <= DW'(point_y) - DW'(end_y);
		end
	end

	// Stage 2: all products.
	logic signed [PW-1:0] uxx_s2, uyy_s2, rxux_s2, ryuy_s2, uyrx_s2, uxry_s2;
	logic signed [PW-1:0] rxx_s2, ryy_s2, wxx_s2, wyy_s2;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			uxx_s2  <= ux_s1 * ux_s1;
			uyy_s2  <= uy_s1 * uy_s1;
			rxux_s2 <= rx_s1 * ux_s1;
			ryuy_s2 <= ry_s1 * uy_s1;
			uyrx_s2 <= uy_s1 * rx_s1;
			uxry_s2 <= ux_s1 * ry_s1;
			rxx_s2  <= rx_s1 * rx_s1;
			ryy_s2  <= ry_s1 * ry_s1;
			wxx_s2  <= wx_s1 * wx_s1;
			wyy_s2  <= wy_s1 * wy_s1;
		end
	end

	// Stage 3: sums. Both signs of the cross product are formed in parallel so
	// that its magnitude needs no second adder.
	logic [RW-1:0]        a_s3, dr_s3, dw_s3, cabs_s3;
	logic signed [RW:0]   b_s3;
	logic signed [PW-1:0] cpos, cneg;

	always_comb begin
		cpos = uyrx_s2 - uxry_s2;
		cneg = uxry_s2 - uyrx_s2;
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			a_s3    <= RW'(uxx_s2) + RW'(uyy_s2);
			b_s3    <= (RW+1)'(rxux_s2 + ryuy_s2);
			dr_s3   <= RW'(rxx_s2) + RW'(ryy_s2);
			dw_s3   <= RW'(wxx_s2) + RW'(wyy_s2);
			cabs_s3 <= cpos[PW-1] ? RW'(cneg) : RW'(cpos);
		end
	end

	// Stage 4: squared cross product, region and endpoint distance.
	logic [RW-1:0]   a_s4;
	logic [2*RW-1:0] c2_s4;
	logic [QW-1:0]   ep_s4;
	region_t         region_s4;
	region_t         region_nx;
	logic [RW-1:0]   ep_sel;

	always_comb begin
		if (a_s3 == '0 || b_s3 < 0) begin
			region_nx = REGION_START;
		end else if (b_s3 > $signed({1'b0, a_s3})) begin
			region_nx = REGION_END;
		end else begin
			region_nx = REGION_INTERIOR;
		end
		ep_sel = (region_nx == REGION_END) ? dw_s3 : dr_s3;
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			a_s4      <= a_s3;
			c2_s4     <= cabs_s3 * cabs_s3;
			ep_s4     <= QW'(ep_sel) << FRAC_BITS;
			region_s4 <= region_nx;
		end
	end

	assign len_sq   = a_s4;
	assign cross_sq = c2_s4;
	assign ep_dist  = ep_s4;
	assign region   = region_s4;

endmodule

// ===== hw/rtl/psd_div_stage.sv =====
// ----------------------------------------------------------------------------
// psd_div_stage
// One restoring division step: develops a single quotient bit per stage.
// ----------------------------------------------------------------------------
module psd_div_stage #(
	parameter int RW = 25,
	parameter int QW = 33
) (
	input  logic             clk,
	input  logic             en,
	input  logic [RW-1:0]    a_in,
	input  logic [RW-1:0]    rem_in,
	input  logic [QW-1:0]    low_in,
	input  logic [QW-1:0]    quot_in,
	input  logic [QW-1:0]    ep_in,
	input  psd_pkg::region_t region_in,
	output logic [RW-1:0]    a_out,
	output logic [RW-1:0]    rem_out,
	output logic [QW-1:0]    low_out,
	output logic [QW-1:0]    quot_out,
	output logic [QW-1:0]    ep_out,
	output psd_pkg::region_t region_out
);
	import psd_pkg::*;

	logic [RW:0]   trial;
	logic [RW+1:0] diff;
	logic          ge;

	always_comb begin
		trial = {rem_in, low_in[QW-1]};
		diff  = {1'b0, trial} - {2'b00, a_in};
		ge    = ~diff[RW+1];
	end

	logic [RW-1:0] a_s1, rem_s1;
	logic [QW-1:0] low_s1, quot_s1, ep_s1;
	region_t       region_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= a_in;
			rem_s1    <= ge ? diff[RW-1:0] : trial[RW-1:0];
			low_s1    <= low_in << 1;
			quot_s1   <= {quot_in[QW-2:0], ge};
			ep_s1     <= ep_in;
			region_s1 <= region_in;
		end
	end

	assign a_out      = a_s1;
	assign rem_out    = rem_s1;
	assign low_out    = low_s1;
	assign quot_out   = quot_s1;
	assign ep_out     = ep_s1;
	assign region_out = region_s1;

endmodule

// ===== hw/rtl/psd_divider.sv =====
// ----------------------------------------------------------------------------
// psd_divider
// Pipelined divider: cross^2 * 2^FRAC_BITS / length^2, one bit per stage.
// ----------------------------------------------------------------------------
module psd_divider #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                       clk,
	input  logic [2*COORD_BITS+FRAC_BITS:0]            stage_en,
	input  logic [2*COORD_BITS:0]                      len_sq,
	input  logic [4*COORD_BITS+1:0]                    cross_sq,
	input  logic [2*COORD_BITS+FRAC_BITS:0]            ep_dist_in,
	input  psd_pkg::region_t                           region_in,
	output logic [2*COORD_BITS+FRAC_BITS:0]            quotient,
	output logic [2*COORD_BITS+FRAC_BITS:0]            ep_dist_out,
	output psd_pkg::region_t                           region_out
);
	import psd_pkg::*;

	localparam int RW = 2 * COORD_BITS + 1;
	localparam int QW = RW + FRAC_BITS;
	localparam int NW = 2 * RW + FRAC_BITS;

	// In the interior case the quotient fits QW bits, so the dividend bits
	// above QW are already below the divisor and form the starting remainder.
	logic [NW-1:0] dividend;

	assign dividend = NW'(cross_sq) << FRAC_BITS;

	logic [RW-1:0] a_w    [QW+1];
	logic [RW-1:0] rem_w  [QW+1];
	logic [QW-1:0] low_w  [QW+1];
	logic [QW-1:0] quot_w [QW+1];
	logic [QW-1:0] ep_w   [QW+1];
	region_t       reg_w  [QW+1];

	assign a_w[0]    = len_sq;
	assign rem_w[0]  = dividend[NW-1:QW];
	assign low_w[0]  = dividend[QW-1:0];
	assign quot_w[0] = '0;
	assign ep_w[0]   = ep_dist_in;
	assign reg_w[0]  = region_in;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		psd_div_stage #(
			.RW(RW),
			.QW(QW)
		) u_stage (
			.clk       (clk),
			.en        (stage_en[i]),
			.a_in      (a_w[i]),
			.rem_in    (rem_w[i]),
			.low_in    (low_w[i]),
			.quot_in   (quot_w[i]),
			.ep_in     (ep_w[i]),
			.region_in (reg_w[i]),
			.a_out     (a_w[i+1]),
			.rem_out   (rem_w[i+1]),
			.low_out   (low_w[i+1]),
			.quot_out  (quot_w[i+1]),
			.ep_out    (ep_w[i+1]),
			.region_out(reg_w[i+1])
		);
	end

	assign quotient    = quot_w[QW];
	assign ep_dist_out = ep_w[QW];
	assign region_out  = reg_w[QW];

endmodule

// ===== hw/rtl/point_segment_square_distance.sv =====
// Pipeline: four front stages, one divider stage per quotient bit and one
// output stage.
// Throughput: one item per cycle unless the output stalls; the divider is
// fully pipelined.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// point_segment_square_distance
// Squared distance from a query point to a line segment, fixed point output.
// ----------------------------------------------------------------------------
module point_segment_square_distance #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// start_x, start_y, end_x, end_y, point_x, point_y (lowest bits first)
	input  logic [((psd_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// sq_distance, then zero fill
	output logic [psd_pkg::OUT_TDATA_W-1:0] m_tdata,
	// nearest_region
	output logic [psd_pkg::REGION_W-1:0] m_tuser
);
	import psd_pkg::*;

	localparam int RW  = 2 * COORD_BITS + 1;
	localparam int QW  = RW + FRAC_BITS;
	localparam int NST = FRONT_STAGES + QW + 1;
	localparam int EW  = (QW > OUT_BITS) ? QW : OUT_BITS;

	logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y, point_x, point_y;

	assign start_x = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign start_y = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign end_x   = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign end_y   = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign point_x = s_tdata[4*COORD_BITS +: COORD_BITS];
	assign point_y = s_tdata[5*COORD_BITS +: COORD_BITS];

	// A stage may load when it is empty or when the stage after it moves, so
	// bubbles are squeezed out while the output is held.
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	logic [NST-1:0] vld_in;

	always_comb begin
		en[NST-1] = m_tready | ~vld_q[NST-1];
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = en[i+1] | ~vld_q[i];
		end
		vld_in = {vld_q[NST-2:0], s_tvalid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_in & en) | (vld_q & ~en);
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NST-1];

	logic [RW-1:0]   len_sq;
	logic [2*RW-1:0] cross_sq;
	logic [QW-1:0]   ep_front, ep_div, quotient;
	region_t         region_front, region_div;

	psd_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.stage_en(en[FRONT_STAGES-1:0]),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.point_x (point_x),
		.point_y (point_y),
		.len_sq  (len_sq),
		.cross_sq(cross_sq),
		.ep_dist (ep_front),
		.region  (region_front)
	);

	psd_divider #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_divider (
		.clk        (clk),
		.stage_en   (en[FRONT_STAGES +: QW]),
		.len_sq     (len_sq),
		.cross_sq   (cross_sq),
		.ep_dist_in (ep_front),
		.region_in  (region_front),
		.quotient   (quotient),
		.ep_dist_out(ep_div),
		.region_out (region_div)
	);

	// Output stage: pick the result for the region and saturate to the port.
	logic [EW-1:0]       dist_w;
	logic                sat;
	logic [OUT_BITS-1:0] out_dist_q;
	region_t             out_region_q;

	always_comb begin
		dist_w = (region_div == REGION_INTERIOR) ? EW'(quotient) : EW'(ep_div);
		sat    = |(dist_w >> OUT_BITS);
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			out_dist_q   <= sat ? '1 : dist_w[OUT_BITS-1:0];
			out_region_q <= region_div;
		end
	end

	assign m_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_dist_q};
	assign m_tuser = out_region_q;

	// An accepted item always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted item did not enter the first stage");

	// Input is refused only while a result waits at the output.
	a_refuse_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input refused without an output stall");

	// Endpoint results are whole numbers unless saturated.
	if (FRAC_BITS > 0) begin : g_frac_chk
		a_endpoint_whole: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && out_region_q != REGION_INTERIOR
			|-> out_dist_q[FRAC_BITS-1:0] == '0 || &out_dist_q)
			else $error("endpoint distance has fractional bits set");
	end

endmodule

// ===== sim/point_segment_square_distance_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_segment_square_distance_tb
// Stream testbench for the point-to-segment squared distance block. A queue
// of queries (directed corner cases, then random segments and points) feeds
// a clocked driver. A clocked monitor compares every result with a local
// prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module point_segment_square_distance_tb;

	import psd_pkg::*;

	localparam int COORD_W    = COORD_BITS_DEF;
	localparam int FRAC_W     = FRAC_BITS_DEF;
	localparam int IN_TDATA_W = ((NUM_COORDS*COORD_W+7)/8)*8;
	localparam int LATENCY    = 2*COORD_W + FRAC_W + 6;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 600000;
	localparam longint SQ_MAX   = (64'd1 << OUT_BITS) - 1;

	// Packed so that start_x lands in the lowest bits of tdata.
	typedef struct packed {
		logic [COORD_W-1:0] py;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] ey;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] sx;
	} query_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] sq_distance;
		region_t             region;
	} distance_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [REGION_W-1:0]    m_tuser;

	query_t    pending_queries[$];
	distance_t expected_distances[$];
	query_t    presented;
	distance_t oldest;
	int        query_total;
	int        accepted_count;
	int        result_count;
	int        mismatch_count;
	int        region_count[3];
	int        send_gap;
	int        send_burst;
	int        recv_stall;
	int        recv_burst;
	int        cycle_count;

	point_segment_square_distance u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic distance_t predict_sq_distance(query_t q);
		longint sx, sy, ex, ey, px, py;
		longint ux, uy, rx, ry, a, b, c, c2, quot, rem, sq_dist;
		distance_t res;
		sx = signed'(q.sx);
		sy = signed'(q.sy);
		ex = signed'(q.ex);
		ey = signed'(q.ey);
		px = signed'(q.px);
		py = signed'(q.py);
		ux = ex - sx;
		uy = ey - sy;
		rx = px - sx;
		ry = py - sy;
		a  = ux*ux + uy*uy;
		b  = rx*ux + ry*uy;
		if (a == 0 || b < 0) begin
			sq_dist    = (rx*rx + ry*ry) << FRAC_W;
			res.region = REGION_START;
		end else if (b > a) begin
			sq_dist    = ((px-ex)*(px-ex) + (py-ey)*(py-ey)) << FRAC_W;
			res.region = REGION_END;
		end else begin
			// Split the division so the scaled remainder never overflows.
			c    = uy*rx - ux*ry;
			c2   = (c < 0) ? -c : c;
			c2   = c2 * c2;
			quot = c2 / a;
			rem  = c2 % a;
			sq_dist = (quot << FRAC_W) + ((rem << FRAC_W) / a);
			res.region = REGION_INTERIOR;
		end
		if (sq_dist > SQ_MAX)
			sq_dist = SQ_MAX;
		res.sq_distance = sq_dist[OUT_BITS-1:0];
		return res;
	endfunction

	function automatic query_t make_query(int sx, int sy, int ex, int ey, int px, int py);
		query_t q;
		q.sx = sx[COORD_W-1:0];
		q.sy = sy[COORD_W-1:0];
		q.ex = ex[COORD_W-1:0];
		q.ey = ey[COORD_W-1:0];
		q.px = px[COORD_W-1:0];
		q.py = py[COORD_W-1:0];
		return q;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 2047)
			return 2047;
		if (v < -2048)
			return -2048;
		return v;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 4))
			0: return -2048;
			1: return 2047;
			2: return 0;
			3: return -1;
			default: return any_coord();
		endcase
	endfunction

	function automatic query_t random_query();
		int kind, t, sx, sy, ex, ey, px, py;
		kind = $urandom_range(0, 99);
		sx = any_coord();
		sy = any_coord();
		ex = any_coord();
		ey = any_coord();
		px = any_coord();
		py = any_coord();
		if (kind < 45) begin
			// Fully random query, mostly lands near one of the end points.
		end else if (kind < 70) begin
			// Point placed along the segment, slightly off it, from half a
			// length before the start to half a length past the end.
			t  = int'($urandom_range(0, 1023)) - 256;
			px = clamp_coord(sx + ((ex - sx) * t) / 512 + int'($urandom_range(0, 64)) - 32);
			py = clamp_coord(sy + ((ey - sy) * t) / 512 + int'($urandom_range(0, 64)) - 32);
		end else if (kind < 80) begin
			// Small coordinates hit projections exactly at an end quite often.
			sx = int'($urandom_range(0, 15)) - 8;
			sy = int'($urandom_range(0, 15)) - 8;
			ex = int'($urandom_range(0, 15)) - 8;
			ey = int'($urandom_range(0, 15)) - 8;
			px = int'($urandom_range(0, 15)) - 8;
			py = int'($urandom_range(0, 15)) - 8;
		end else if (kind < 86) begin
			ex = sx;
			ey = sy;
		end else if (kind < 94) begin
			sx = extreme_coord();
			sy = extreme_coord();
			ex = extreme_coord();
			ey = extreme_coord();
			px = extreme_coord();
			py = extreme_coord();
		end else if (kind < 97) begin
			px = clamp_coord(ex + int'($urandom_range(0, 4)) - 2);
			py = clamp_coord(ey + int'($urandom_range(0, 4)) - 2);
		end else begin
			px = clamp_coord(sx + int'($urandom_range(0, 4)) - 2);
			py = clamp_coord(sy + int'($urandom_range(0, 4)) - 2);
		end
		return make_query(sx, sy, ex, ey, px, py);
	endfunction

	// Idle length after one item: mostly none or short, now and then long,
	// and occasional runs of items with no idling at all.
	function automatic int idle_length(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(30, 120);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Driver: presents queued queries and records a prediction per accepted item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap   = 0;
			send_burst = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_distances.push_back(predict_sq_distance(presented));
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_queries.size() > 0) begin
					presented = pending_queries.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= presented;
					send_gap = idle_length(send_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
			recv_burst = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_count++;
				if (expected_distances.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result with nothing expected: sq_distance=%0d region=%0d",
							m_tdata, m_tuser);
				end else begin
					oldest = expected_distances.pop_front();
					region_count[int'(oldest.region)]++;
					if (m_tdata !== OUT_TDATA_W'(oldest.sq_distance) ||
							m_tuser !== oldest.region) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch on result %0d: expected %0d/%0d, got %0d/%0d",
								result_count, oldest.sq_distance, oldest.region,
								m_tdata, m_tuser);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_stall = idle_length(recv_burst);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[point_segment_square_distance] ERROR");
			$finish;
		end
	end

	initial begin
		// Corner cases first: extremes, degenerate segments, each region and
		// projections that fall exactly on an end point.
		pending_queries.push_back(make_query(-2048, -2048, -2048, -2048, -2048, -2048));
		pending_queries.push_back(make_query(2047, 2047, 2047, 2047, 2047, 2047));
		pending_queries.push_back(make_query(-2048, -2048, -2048, -2048, 2047, 2047));
		pending_queries.push_back(make_query(2047, 2047, 2047, 2047, -2048, -2048));
		pending_queries.push_back(make_query(-2048, -2048, 2047, 2047, 2047, -2048));
		pending_queries.push_back(make_query(-2048, 2047, 2047, -2048, -2048, -2048));
		pending_queries.push_back(make_query(0, 0, 10, 0, -3, 4));
		pending_queries.push_back(make_query(0, 0, 10, 0, 15, -7));
		pending_queries.push_back(make_query(0, 0, 10, 0, 0, 5));
		pending_queries.push_back(make_query(0, 0, 10, 0, 10, 5));
		pending_queries.push_back(make_query(0, 0, 10, 0, 4, 0));
		pending_queries.push_back(make_query(0, 0, 3, 1, 1, 2));
		pending_queries.push_back(make_query(5, -100, 5, 100, -7, 3));
		pending_queries.push_back(make_query(-1, -1, -1, -1, -1, -1));
		pending_queries.push_back(make_query(1365, -1366, -1366, 1365, 1365, 1365));
		pending_queries.push_back(make_query(-2048, 0, 2047, 0, 0, 2047));
		pending_queries.push_back(make_query(2047, 2047, -2048, -2048, -2048, 2047));
		pending_queries.push_back(make_query(1, 0, 0, 1, 0, 0));
		pending_queries.push_back(make_query(0, 0, -2048, -2048, 2047, 2047));
		pending_queries.push_back(make_query(-2048, -2048, 0, 0, 2047, 2047));
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_queries.push_back(random_query());
		query_total = pending_queries.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < query_total || expected_distances.size() > 0)
			@(posedge clk);
		repeat (2*LATENCY + 20) @(posedge clk);

		$display("%0d queries checked: %0d nearest the start, %0d nearest the end, %0d interior",
			result_count, region_count[0], region_count[1], region_count[2]);
		$display("covered corner cases, degenerate segments and near-end points, random idling");
		if (mismatch_count == 0 && expected_distances.size() == 0) begin
			$display("[point_segment_square_distance] OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("[point_segment_square_distance] ERROR");
		end
		$finish;
	end

endmodule
